### rtl/core/npvl_pkg.sv
// ----------------------------------------------------------------------------
// npvl_pkg
// Shared widths, codes and types for the nearest-point vol lookup core.
// ----------------------------------------------------------------------------
package npvl_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KIND_W   = 2;
    localparam int STRIKE_W = 32;
    localparam int EXPIRY_W = 24;
    localparam int VOL_W    = 20;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    localparam int DS2_W    = 2 * STRIKE_W;
    localparam int DE2_W    = 2 * EXPIRY_W;
    localparam int DIST_W   = DS2_W + 1;

    localparam logic [VOL_W-1:0] VOL_LIMIT_RST = VOL_W'(655360);

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_STRIKE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_EXPIRY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_VOL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

    typedef struct packed {
        logic [STRIKE_W-1:0] strike;
        logic [EXPIRY_W-1:0] expiry;
        logic [VOL_W-1:0]    vol;
    } t_point;

    // travels alongside each table read through the distance pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_scan_tag;

endpackage

### rtl/core/npvl_store.sv
// ----------------------------------------------------------------------------
// npvl_store
// Point table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module npvl_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [npvl_pkg::IDX_W-1:0] i_waddr,
    input  npvl_pkg::t_point           i_wdata,
    input  logic [npvl_pkg::IDX_W-1:0] i_raddr,
    output npvl_pkg::t_point           o_rdata
);

    npvl_pkg::t_point r_mem [npvl_pkg::CAPACITY];
    npvl_pkg::t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/npvl_dist.sv
// ----------------------------------------------------------------------------
// npvl_dist
// Distance unit: abs diff, square, sum, running minimum.
// One table entry enters per cycle; done pulses after the last one.
// ----------------------------------------------------------------------------
module npvl_dist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  npvl_pkg::t_scan_tag           i_tag,
    input  npvl_pkg::t_point              i_point,
    input  logic [npvl_pkg::STRIKE_W-1:0] i_q_strike,
    input  logic [npvl_pkg::EXPIRY_W-1:0] i_q_expiry,
    output logic                          o_done,
    output logic [npvl_pkg::VOL_W-1:0]    o_best_vol
);

    // stage 1: absolute differences
    npvl_pkg::t_scan_tag           r1_tag;
    logic [npvl_pkg::STRIKE_W-1:0] r1_ds;
    logic [npvl_pkg::EXPIRY_W-1:0] r1_de;
    logic [npvl_pkg::VOL_W-1:0]    r1_vol;
    // stage 2: squares
    npvl_pkg::t_scan_tag           r2_tag;
    logic [npvl_pkg::DS2_W-1:0]    r2_a;
    logic [npvl_pkg::DE2_W-1:0]    r2_b;
    logic [npvl_pkg::VOL_W-1:0]    r2_vol;
    // stage 3: sum
    npvl_pkg::t_scan_tag           r3_tag;
    logic [npvl_pkg::DIST_W-1:0]   r3_sum;
    logic [npvl_pkg::VOL_W-1:0]    r3_vol;
    // stage 4: running best
    logic [npvl_pkg::DIST_W-1:0]   r_best;
    logic [npvl_pkg::VOL_W-1:0]    r_best_vol;
    logic                          r_done;

    logic [npvl_pkg::STRIKE_W-1:0] n_ds;
    logic [npvl_pkg::EXPIRY_W-1:0] n_de;
    logic                          n_take;

    always_comb begin
        n_ds = (i_q_strike >= i_point.strike) ? (i_q_strike - i_point.strike)
                                              : (i_point.strike - i_q_strike);
        n_de = (i_q_expiry >= i_point.expiry) ? (i_q_expiry - i_point.expiry)
                                              : (i_point.expiry - i_q_expiry);
        // strict less-than keeps the earliest entry on a tie
        n_take = r3_tag.first || (r3_sum < r_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
            r_done <= 1'b0;
        end else begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
            r_done <= r3_tag.valid && r3_tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ds  <= n_ds;
        r1_de  <= n_de;
        r1_vol <= i_point.vol;

        r2_a   <= npvl_pkg::DS2_W'(r1_ds) * npvl_pkg::DS2_W'(r1_ds);
        r2_b   <= npvl_pkg::DE2_W'(r1_de) * npvl_pkg::DE2_W'(r1_de);
        r2_vol <= r1_vol;

        r3_sum <= npvl_pkg::DIST_W'(r2_a) + npvl_pkg::DIST_W'(r2_b);
        r3_vol <= r2_vol;

        if (r3_tag.valid && n_take) begin
            r_best     <= r3_sum;
            r_best_vol <= r3_vol;
        end
    end

    assign o_done     = r_done;
    assign o_best_vol = r_best_vol;

endmodule

### rtl/core/nearest_point_vol_lookup_core.sv
// ----------------------------------------------------------------------------
// nearest_point_vol_lookup_core
// Point table of (strike, expiry, vol) with add, clear and nearest query.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: i_kind/i_strike/i_expiry/i_vol taken on a clock edge with
//   start high and busy low. Every beat gives exactly one result beat on
//   o_done, held for one cycle, with o_status/o_near_vol/o_entry_count.
//   Add, clear and unused kinds: result in the cycle after the accept edge;
//   busy stays low, so such beats can follow back to back.
//   Query on a table of N > 0 points: the table is read one entry per cycle
//   through a four-stage distance pipeline (abs diff, square, sum, min).
//   The result appears once the distance unit signals done, and busy is
//   high until then, so no new beat is taken while a query runs. A query
//   on an empty table answers in the next cycle.
//   vol_limit is written with i_cfg_we/i_cfg_wdata; the user must write it only while idle (not enforced).
//   Reset (i_rst_n low, synchronous) empties the table and restores
//   vol_limit to 10.0; table contents are not cleared, only the count.
//   The receiver cannot stall: a result beat is gone after its one cycle.
// ----------------------------------------------------------------------------
module nearest_point_vol_lookup_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [npvl_pkg::KIND_W-1:0]   i_kind,
    input  logic [npvl_pkg::STRIKE_W-1:0] i_strike,
    input  logic [npvl_pkg::EXPIRY_W-1:0] i_expiry,
    input  logic [npvl_pkg::VOL_W-1:0]    i_vol,
    input  logic                          i_cfg_we,
    input  logic [npvl_pkg::VOL_W-1:0]    i_cfg_wdata,
    output logic                          o_done,
    output logic [npvl_pkg::STATUS_W-1:0] o_status,
    output logic [npvl_pkg::VOL_W-1:0]    o_near_vol,
    output logic [npvl_pkg::COUNT_W-1:0]  o_entry_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } t_state;

    t_state                        r_state;
    logic [npvl_pkg::CNT_W-1:0]    r_fill;
    logic [npvl_pkg::IDX_W-1:0]    r_rd_idx;
    logic [npvl_pkg::VOL_W-1:0]    r_vol_limit;
    logic [npvl_pkg::STRIKE_W-1:0] r_q_strike;
    logic [npvl_pkg::EXPIRY_W-1:0] r_q_expiry;
    npvl_pkg::t_scan_tag           r_tag;
    logic                          r_done;
    logic [npvl_pkg::STATUS_W-1:0] r_status;
    logic [npvl_pkg::VOL_W-1:0]    r_near_vol;
    logic [npvl_pkg::CNT_W-1:0]    r_count;

    logic                          w_accept;
    logic                          w_full;
    logic                          w_last;
    logic [npvl_pkg::STATUS_W-1:0] n_add_status;
    logic                          w_we;
    npvl_pkg::t_point              w_wdata;
    npvl_pkg::t_point              w_rdata;
    logic                          w_dist_done;
    logic [npvl_pkg::VOL_W-1:0]    w_best_vol;

    assign w_accept = start && !busy;
    assign w_full   = r_fill >= npvl_pkg::CNT_W'(npvl_pkg::CAPACITY);
    assign w_last   = (npvl_pkg::CNT_W'(r_rd_idx) + npvl_pkg::CNT_W'(1)) == r_fill;

    always_comb begin
        if (i_strike == '0) begin
            n_add_status = npvl_pkg::ST_BAD_STRIKE;
        end else if (i_expiry == '0) begin
            n_add_status = npvl_pkg::ST_BAD_EXPIRY;
        end else if (i_vol > r_vol_limit) begin
            n_add_status = npvl_pkg::ST_BAD_VOL;
        end else if (w_full) begin
            n_add_status = npvl_pkg::ST_FULL;
        end else begin
            n_add_status = npvl_pkg::ST_OK;
        end
    end

    assign w_we = w_accept && (i_kind == npvl_pkg::KIND_ADD) &&
                  (n_add_status == npvl_pkg::ST_OK);
    assign w_wdata.strike = i_strike;
    assign w_wdata.expiry = i_expiry;
    assign w_wdata.vol    = i_vol;

    npvl_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[npvl_pkg::IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    // r_tag is registered alongside the table read, so it lines up with w_rdata
    npvl_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (r_tag),
        .i_point    (w_rdata),
        .i_q_strike (r_q_strike),
        .i_q_expiry (r_q_expiry),
        .o_done     (w_dist_done),
        .o_best_vol (w_best_vol)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_limit <= npvl_pkg::VOL_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_vol_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_tag   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_tag  <= '0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_near_vol <= '0;
                        unique case (i_kind)
                            npvl_pkg::KIND_ADD: begin
                                r_done   <= 1'b1;
                                r_status <= n_add_status;
                                if (w_we) begin
                                    r_fill  <= r_fill + npvl_pkg::CNT_W'(1);
                                    r_count <= r_fill + npvl_pkg::CNT_W'(1);
                                end else begin
                                    r_count <= r_fill;
                                end
                            end
                            npvl_pkg::KIND_CLEAR: begin
                                r_done   <= 1'b1;
                                r_status <= npvl_pkg::ST_OK;
                                r_fill   <= '0;
                                r_count  <= '0;
                            end
                            npvl_pkg::KIND_QUERY: begin
                                if (r_fill == '0) begin
                                    r_done   <= 1'b1;
                                    r_status <= npvl_pkg::ST_EMPTY;
                                    r_count  <= r_fill;
                                end else begin
                                    r_q_strike <= i_strike;
                                    r_q_expiry <= i_expiry;
                                    r_rd_idx   <= '0;
                                    r_state    <= S_SCAN;
                                end
                            end
                            default: begin
                                r_done   <= 1'b1;
                                r_status <= npvl_pkg::ST_OK;
                                r_count  <= r_fill;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_tag.valid <= 1'b1;
                    r_tag.first <= (r_rd_idx == '0);
                    r_tag.last  <= w_last;
                    if (w_last) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_rd_idx <= r_rd_idx + npvl_pkg::IDX_W'(1);
                    end
                end
                S_WAIT: begin
                    if (w_dist_done) begin
                        r_done     <= 1'b1;
                        r_status   <= npvl_pkg::ST_OK;
                        r_near_vol <= w_best_vol;
                        r_count    <= r_fill;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_near_vol    = r_near_vol;
    assign o_entry_count = npvl_pkg::COUNT_W'(r_count);

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= npvl_pkg::CNT_W'(npvl_pkg::CAPACITY))
        else $error("fill count above capacity");

    a_dist_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dist_done |-> (r_state == S_WAIT))
        else $error("distance unit finished outside of wait state");

    a_tag_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag.valid |-> (r_state == S_SCAN || r_state == S_WAIT))
        else $error("table read tag outside of a scan");

    a_query_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == npvl_pkg::KIND_QUERY && r_fill != '0) |=> busy && !r_done)
        else $error("query on a filled table did not start a scan");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_WAIT && r_done) |-> !busy)
        else $error("query result issued while still busy");
`endif

endmodule
